FILE: rtl/core/stepper_speed_to_timer_settings_defines.svh
// Assertion macros shared by the RTL of the stepper speed to timer settings block.
`ifndef STEPPER_SPEED_TO_TIMER_SETTINGS_DEFINES_SVH
`define STEPPER_SPEED_TO_TIMER_SETTINGS_DEFINES_SVH
`ifndef SYNTH
`define SSTTS_ASSERT_IMPL(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("implication check failed");
`define SSTTS_ASSERT_NEXT(lbl, cond, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("next-cycle check failed");
`else
`define SSTTS_ASSERT_IMPL(lbl, cond, expr)
`define SSTTS_ASSERT_NEXT(lbl, cond, expr)
`endif
`endif

FILE: rtl/core/sstts_pkg.sv
// Types shared between the sequencer and the serial arithmetic unit.
`timescale 1ns / 1ps
package sstts_pkg;

  localparam int unsigned OpW  = 64;
  localparam int unsigned CntW = 7;

  typedef struct packed {
    logic            go;
    logic            is_div;
    logic [CntW-1:0] nbits;
    logic [OpW-1:0]  a;
    logic [OpW-1:0]  b;
  } alu_ctrl_t;

  typedef struct packed {
    logic           done;
    logic           rem_nz;
    logic [OpW-1:0] result;
  } alu_stat_t;

endpackage

FILE: rtl/core/sstts_alu.sv
// Bit-serial shift-add multiplier and restoring divider sharing one accumulator.
`timescale 1ns / 1ps
module sstts_alu
  import sstts_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  alu_ctrl_t ctrl,
  output alu_stat_t stat
);

  logic [OpW-1:0]  acc_r, acc_nxt;
  logic [OpW-1:0]  opa_r, opa_nxt;
  logic [OpW-1:0]  opb_r;
  logic [CntW-1:0] cnt_r;
  logic            is_div_r, busy_r, done_r;
  logic [OpW:0]    rem_sh;
  logic [OpW:0]    rem_sub;

  // A divide step brings down one dividend bit; a multiply step adds one partial product.
  always_comb begin
    rem_sh  = {acc_r, opa_r[OpW-1]};
    rem_sub = rem_sh - {1'b0, opb_r};
    if (is_div_r) begin
      if (rem_sh >= {1'b0, opb_r}) begin
        acc_nxt = rem_sub[OpW-1:0];
        opa_nxt = {opa_r[OpW-2:0], 1'b1};
      end else begin
        acc_nxt = rem_sh[OpW-1:0];
        opa_nxt = {opa_r[OpW-2:0], 1'b0};
      end
    end else begin
      acc_nxt = opb_r[0] ? acc_r + opa_r : acc_r;
      opa_nxt = {opa_r[OpW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctrl.go) begin
        acc_r    <= '0;
        opa_r    <= ctrl.a;
        opb_r    <= ctrl.b;
        cnt_r    <= ctrl.nbits;
        is_div_r <= ctrl.is_div;
        busy_r   <= 1'b1;
      end else if (busy_r) begin
        acc_r <= acc_nxt;
        opa_r <= opa_nxt;
        if (!is_div_r) begin
          opb_r <= {1'b0, opb_r[OpW-1:1]};
        end
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CntW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.done   = done_r;
  assign stat.rem_nz = (acc_r != '0);
  assign stat.result = is_div_r ? opa_r : acc_r;

endmodule

FILE: rtl/core/stepper_speed_to_timer_settings.sv
// Top level: converts a joint speed command into step timer prescaler, reload and compare.
`timescale 1ns / 1ps
// How to use this block:
// The input channel (in_valid, in_stall, in_joint_speed) takes one signed Q16.16 joint
// speed per item. The result channel (out_valid, out_stall, out_*) returns exactly one
// item for every input item, in order. An item moves when valid is high and stall is low.
// Each item runs as a chain of serial multiplies and divides on one shared arithmetic
// unit that retires one bit per cycle, so the time an item takes is set by the operand
// widths; an applied request runs twelve operations in turn. A negative request or a
// zero transform factor skips the arithmetic; a request that stops the motor or exceeds
// the maximum speed ends after its first divide.
// Only one item is in flight; in_stall is high until its result has been loaded into
// the output register. That register holds the result while out_stall is high, and
// the block already accepts the next item meanwhile; a second finished result waits
// inside the block until the first one is taken.
// Reset (synchronous, active low) loads the register defaults and clears the held
// prescaler, reload, compare and motor speed. Registers are written through the APB
// port at byte address 4*index and should only be changed while the block is idle.
module stepper_speed_to_timer_settings
  import sstts_pkg::*;
#(
  parameter int unsigned PERIOD_LIMIT = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_joint_speed,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_accepted,
  output logic        out_stopped,
  output logic        out_saturated,
  output logic [15:0] out_prescaler_setting,
  output logic [15:0] out_reload_setting,
  output logic [15:0] out_compare_setting,
  output logic [31:0] out_actual_joint_speed,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  `include "stepper_speed_to_timer_settings_defines.svh"

  localparam int unsigned PlW = $clog2(PERIOD_LIMIT + 1);

  localparam logic [2:0] RegClock  = 3'd0;
  localparam logic [2:0] RegAngle  = 3'd1;
  localparam logic [2:0] RegPulse  = 3'd2;
  localparam logic [2:0] RegMin    = 3'd3;
  localparam logic [2:0] RegMax    = 3'd4;
  localparam logic [2:0] RegFactor = 3'd5;

  localparam logic [63:0] NsPerSec = 64'd1000000000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_MDIV, ST_KMUL, ST_D1MUL, ST_PDIV, ST_D2MUL, ST_NDIV,
    ST_WMUL, ST_D3MUL, ST_CDIV, ST_D4MUL, ST_SDIV, ST_JMUL, ST_EMIT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [27:0] clock_hz_r;
  logic [31:0] angle_r, min_r, max_r, factor_r;
  logic [19:0] pulse_ns_r;

  // State kept between items.
  logic [15:0] held_p_r, held_n_r, held_c_r;
  logic [31:0] held_s_r;

  // Working values of the item in flight.
  logic [31:0] m_r;
  logic [59:0] k_r;
  logic [47:0] wk_r;
  logic [16:0] p_r, n_r, c_r;
  logic [31:0] s_r;
  logic        sat_r;

  // Finished result waiting for the output register.
  logic        res_acc_r, res_stop_r, res_sat_r;
  logic [15:0] res_p_r, res_n_r, res_c_r;
  logic [31:0] res_j_r;

  // Output register.
  logic        out_valid_r, o_acc_r, o_stop_r, o_sat_r;
  logic [15:0] o_p_r, o_n_r, o_c_r;
  logic [31:0] o_j_r;

  // Launch of the shared arithmetic unit.
  logic            go_r, op_div_r;
  logic [CntW-1:0] op_n_r;
  logic [63:0]     op_a_r, op_b_r;

  alu_ctrl_t alu_ctrl;
  alu_stat_t alu_stat;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;
  logic [64:0] q_up;
  logic [63:0] q;
  logic [16:0] s_pn;

  function automatic logic [16:0] clamp_ticks(input logic [64:0] v);
    if (v == '0) begin
      return 17'd1;
    end else if (v > 65'd65536) begin
      return 17'd65536;
    end
    return v[16:0];
  endfunction

  function automatic logic clamp_hit(input logic [64:0] v);
    return (v == '0) || (v > 65'd65536);
  endfunction

  assign alu_ctrl = '{go: go_r, is_div: op_div_r, nbits: op_n_r, a: op_a_r, b: op_b_r};

  sstts_alu u_alu (
    .clk  (clk),
    .rst_n(rst_n),
    .ctrl (alu_ctrl),
    .stat (alu_stat)
  );

  assign q    = alu_stat.result;
  assign q_up = {1'b0, q} + {64'd0, alu_stat.rem_nz};
  assign s_pn = 17'(p_r - 17'd1);

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[4:2];
  assign pready  = 1'b1;

  always_comb begin
    unique case (cfg_idx)
      RegClock:  prdata = {4'd0, clock_hz_r};
      RegAngle:  prdata = angle_r;
      RegPulse:  prdata = {12'd0, pulse_ns_r};
      RegMin:    prdata = min_r;
      RegMax:    prdata = max_r;
      RegFactor: prdata = factor_r;
      default:   prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      go_r        <= 1'b0;
      out_valid_r <= 1'b0;
      clock_hz_r  <= 28'd84000000;
      angle_r     <= 32'd527061;
      pulse_ns_r  <= 20'd10000;
      min_r       <= '0;
      max_r       <= 32'hFFFF_FFFF;
      factor_r    <= 32'd65536;
      held_p_r    <= '0;
      held_n_r    <= '0;
      held_c_r    <= '0;
      held_s_r    <= '0;
    end else begin
      go_r <= 1'b0;
      if (cfg_wr) begin
        unique case (cfg_idx)
          RegClock:  clock_hz_r <= pwdata[27:0];
          RegAngle:  angle_r    <= pwdata;
          RegPulse:  pulse_ns_r <= pwdata[19:0];
          RegMin:    min_r      <= pwdata;
          RegMax:    max_r      <= pwdata;
          RegFactor: factor_r   <= pwdata;
          default:   ;
        endcase
      end
      // In the emit state the output register is reloaded below instead.
      if (out_valid_r && !out_stall && state_r != ST_EMIT) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            res_acc_r  <= 1'b0;
            res_stop_r <= 1'b0;
            res_sat_r  <= 1'b0;
            res_p_r    <= '0;
            res_n_r    <= '0;
            res_c_r    <= '0;
            res_j_r    <= '0;
            sat_r      <= 1'b0;
            if (in_joint_speed[31] || factor_r == '0) begin
              state_r <= ST_EMIT;
            end else begin
              // Motor speed: joint speed shifted up 16 places over the transform factor.
              go_r     <= 1'b1;
              op_div_r <= 1'b1;
              op_a_r   <= {in_joint_speed[30:0], 33'd0};
              op_b_r   <= {32'd0, factor_r};
              op_n_r   <= CntW'(47);
              state_r  <= ST_MDIV;
            end
          end
        end
        ST_MDIV: begin
          if (alu_stat.done) begin
            if (q > {32'd0, max_r}) begin
              state_r <= ST_EMIT;
            end else if (q < {32'd0, min_r} || q == '0) begin
              held_c_r   <= 16'hFFFF;
              held_s_r   <= '0;
              res_acc_r  <= 1'b1;
              res_stop_r <= 1'b1;
              res_p_r    <= held_p_r;
              res_n_r    <= held_n_r;
              res_c_r    <= 16'hFFFF;
              state_r    <= ST_EMIT;
            end else begin
              m_r      <= q[31:0];
              go_r     <= 1'b1;
              op_div_r <= 1'b0;
              op_a_r   <= {36'd0, clock_hz_r};
              op_b_r   <= {32'd0, angle_r};
              op_n_r   <= CntW'(32);
              state_r  <= ST_KMUL;
            end
          end
        end
        ST_KMUL: begin
          if (alu_stat.done) begin
            k_r      <= q[59:0];
            go_r     <= 1'b1;
            op_a_r   <= {24'd0, m_r, 8'd0};
            op_b_r   <= 64'(PERIOD_LIMIT);
            op_n_r   <= CntW'(PlW);
            state_r  <= ST_D1MUL;
          end
        end
        ST_D1MUL: begin
          if (alu_stat.done) begin
            go_r     <= 1'b1;
            op_div_r <= 1'b1;
            op_a_r   <= {k_r, 4'd0};
            op_b_r   <= q;
            op_n_r   <= CntW'(60);
            state_r  <= ST_PDIV;
          end
        end
        ST_PDIV: begin
          if (alu_stat.done) begin
            // Smallest prescaler: the quotient rounded up.
            p_r      <= clamp_ticks(q_up);
            sat_r    <= sat_r | clamp_hit(q_up);
            go_r     <= 1'b1;
            op_div_r <= 1'b0;
            op_a_r   <= {24'd0, m_r, 8'd0};
            op_b_r   <= {47'd0, clamp_ticks(q_up)};
            op_n_r   <= CntW'(17);
            state_r  <= ST_D2MUL;
          end
        end
        ST_D2MUL: begin
          if (alu_stat.done) begin
            go_r     <= 1'b1;
            op_div_r <= 1'b1;
            op_a_r   <= {k_r, 4'd0};
            op_b_r   <= q;
            op_n_r   <= CntW'(60);
            state_r  <= ST_NDIV;
          end
        end
        ST_NDIV: begin
          if (alu_stat.done) begin
            n_r      <= clamp_ticks({1'b0, q});
            sat_r    <= sat_r | clamp_hit({1'b0, q});
            go_r     <= 1'b1;
            op_div_r <= 1'b0;
            op_a_r   <= {44'd0, pulse_ns_r};
            op_b_r   <= {36'd0, clock_hz_r};
            op_n_r   <= CntW'(28);
            state_r  <= ST_WMUL;
          end
        end
        ST_WMUL: begin
          if (alu_stat.done) begin
            wk_r     <= q[47:0];
            go_r     <= 1'b1;
            op_a_r   <= NsPerSec;
            op_b_r   <= {47'd0, p_r};
            op_n_r   <= CntW'(17);
            state_r  <= ST_D3MUL;
          end
        end
        ST_D3MUL: begin
          if (alu_stat.done) begin
            go_r     <= 1'b1;
            op_div_r <= 1'b1;
            op_a_r   <= {wk_r, 16'd0};
            op_b_r   <= q;
            op_n_r   <= CntW'(48);
            state_r  <= ST_CDIV;
          end
        end
        ST_CDIV: begin
          if (alu_stat.done) begin
            c_r      <= clamp_ticks(q_up);
            sat_r    <= sat_r | clamp_hit(q_up);
            go_r     <= 1'b1;
            op_div_r <= 1'b0;
            op_a_r   <= {47'd0, n_r};
            op_b_r   <= {47'd0, p_r};
            op_n_r   <= CntW'(17);
            state_r  <= ST_D4MUL;
          end
        end
        ST_D4MUL: begin
          if (alu_stat.done) begin
            // Actual motor speed uses the truncated period.
            go_r     <= 1'b1;
            op_div_r <= 1'b1;
            op_a_r   <= {k_r, 4'd0};
            op_b_r   <= {q[55:0], 8'd0};
            op_n_r   <= CntW'(60);
            state_r  <= ST_SDIV;
          end
        end
        ST_SDIV: begin
          go_r     <= alu_stat.done;
          op_div_r <= 1'b0;
          op_b_r   <= {32'd0, factor_r};
          op_n_r   <= CntW'(32);
          if (alu_stat.done) begin
            if (q[63:32] != '0) begin
              s_r    <= 32'hFFFF_FFFF;
              op_a_r <= 64'h0000_0000_FFFF_FFFF;
              sat_r  <= 1'b1;
            end else begin
              s_r    <= q[31:0];
              op_a_r <= {32'd0, q[31:0]};
            end
            state_r <= ST_JMUL;
          end
        end
        ST_JMUL: begin
          if (alu_stat.done) begin
            held_p_r   <= s_pn[15:0];
            held_n_r   <= 16'(n_r - 17'd1);
            held_c_r   <= 16'(c_r - 17'd1);
            held_s_r   <= s_r;
            res_acc_r  <= 1'b1;
            res_p_r    <= s_pn[15:0];
            res_n_r    <= 16'(n_r - 17'd1);
            res_c_r    <= 16'(c_r - 17'd1);
            if (q[63:48] != '0) begin
              res_j_r   <= 32'hFFFF_FFFF;
              res_sat_r <= 1'b1;
            end else begin
              res_j_r   <= q[47:16];
              res_sat_r <= sat_r;
            end
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            o_acc_r     <= res_acc_r;
            o_stop_r    <= res_stop_r;
            o_sat_r     <= res_sat_r;
            o_p_r       <= res_p_r;
            o_n_r       <= res_n_r;
            o_c_r       <= res_c_r;
            o_j_r       <= res_j_r;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_stall               = (state_r != ST_IDLE);
  assign out_valid              = out_valid_r;
  assign out_accepted           = o_acc_r;
  assign out_stopped            = o_stop_r;
  assign out_saturated          = o_sat_r;
  assign out_prescaler_setting  = o_p_r;
  assign out_reload_setting     = o_n_r;
  assign out_compare_setting    = o_c_r;
  assign out_actual_joint_speed = o_j_r;

  // An accepted item always closes the input in the next cycle.
  `SSTTS_ASSERT_NEXT(a_accept_blocks, in_valid && !in_stall, in_stall)
  // A stopped result is applied and parks the compare at all ones with zero speed.
  `SSTTS_ASSERT_IMPL(a_stop_fields, out_valid && out_stopped, out_accepted && (out_compare_setting == 16'hFFFF) && (out_actual_joint_speed == 32'd0))
  // A rejected request reports nothing else.
  `SSTTS_ASSERT_IMPL(a_reject_zero, out_valid && !out_accepted, !out_stopped && !out_saturated && (out_compare_setting == 16'd0))
  // The arithmetic unit is only launched while an item is in flight.
  `SSTTS_ASSERT_IMPL(a_go_busy, go_r, state_r != ST_IDLE && state_r != ST_EMIT)

endmodule

FILE: sim/tb_stepper_speed_to_timer_settings.sv
// Testbench for the stepper speed to timer settings block: predicted timer settings vs. results.
`timescale 1ns / 1ps
module tb_stepper_speed_to_timer_settings;

  // Register indexes of the configuration port; each lies at byte address 4*index.
  typedef enum int unsigned {
    REG_TIMER_CLOCK  = 0,
    REG_STEP_ANGLE   = 1,
    REG_PULSE_WIDTH  = 2,
    REG_MIN_SPEED    = 3,
    REG_MAX_SPEED    = 4,
    REG_TRANSFORM    = 5
  } cfg_reg_t;

  localparam longint unsigned TICK_LIMIT = 65536;
  localparam bit [15:0] STOP_COMPARE = 16'hFFFF;
  localparam int unsigned CYCLE_LIMIT = 4000000;
  localparam int unsigned DRAIN_CYCLES = 600;

  // One item of the result channel.
  typedef struct {
    bit        accepted;
    bit        stopped;
    bit        saturated;
    bit [15:0] prescaler;
    bit [15:0] reload;
    bit [15:0] compare;
    bit [31:0] joint_speed;
  } timer_settings_t;

  // Computes the timer settings for each accepted speed request and holds them
  // until the matching result arrives.
  class timer_settings_scoreboard;
    bit [31:0] clock_hz = 84000000;
    bit [31:0] angle = 527061;
    bit [31:0] pulse_ns = 10000;
    bit [31:0] min_speed = 0;
    bit [31:0] max_speed = 32'hFFFFFFFF;
    bit [31:0] transform = 65536;
    bit [15:0] held_prescaler;
    bit [15:0] held_reload;
    bit [15:0] held_compare;
    bit [31:0] held_speed;
    timer_settings_t pending[$];
    int errors;

    function longint unsigned ceil_div(longint unsigned a, longint unsigned b);
      return a / b + ((a % b) != 0 ? 1 : 0);
    endfunction

    function longint unsigned clamp_ticks(longint unsigned v, ref bit sat);
      if (v < 1) begin
        sat = 1;
        return 1;
      end
      if (v > TICK_LIMIT) begin
        sat = 1;
        return TICK_LIMIT;
      end
      return v;
    endfunction

    function void set_reg(cfg_reg_t idx, bit [31:0] v);
      case (idx)
        REG_TIMER_CLOCK: clock_hz = v & 32'h0FFFFFFF;
        REG_STEP_ANGLE:  angle = v;
        REG_PULSE_WIDTH: pulse_ns = v & 32'h000FFFFF;
        REG_MIN_SPEED:   min_speed = v;
        REG_MAX_SPEED:   max_speed = v;
        REG_TRANSFORM:   transform = v;
        default: ;
      endcase
    endfunction

    function void note_request(bit [31:0] js);
      timer_settings_t r;
      longint unsigned m, k, p, n, c, s, j;
      bit sat;
      r = '{default: 0};
      sat = 0;
      // Negative requests and a zero factor are rejected with an all-zero result.
      if (js[31] || transform == 0) begin
        pending.push_back(r);
        return;
      end
      m = ({32'd0, js} << 16) / transform;
      if (m > max_speed) begin
        pending.push_back(r);
        return;
      end
      // Below the minimum, or a zero speed, stops the pulses but keeps the timing.
      if (m < min_speed || m == 0) begin
        held_compare = STOP_COMPARE;
        held_speed = 0;
        r.accepted = 1;
        r.stopped = 1;
        r.prescaler = held_prescaler;
        r.reload = held_reload;
        r.compare = STOP_COMPARE;
        pending.push_back(r);
        return;
      end
      k = longint'(clock_hz) * angle;
      p = clamp_ticks(ceil_div(k, TICK_LIMIT * (m << 8)), sat);
      n = clamp_ticks(k / (p * (m << 8)), sat);
      c = clamp_ticks(ceil_div(longint'(pulse_ns) * clock_hz, p * 1000000000), sat);
      s = k / ((p * n) << 8);
      if (s > 64'hFFFFFFFF) begin
        s = 64'hFFFFFFFF;
        sat = 1;
      end
      j = (s * transform) >> 16;
      if (j > 64'hFFFFFFFF) begin
        j = 64'hFFFFFFFF;
        sat = 1;
      end
      held_prescaler = 16'(p - 1);
      held_reload = 16'(n - 1);
      held_compare = 16'(c - 1);
      held_speed = 32'(s);
      r.accepted = 1;
      r.saturated = sat;
      r.prescaler = held_prescaler;
      r.reload = held_reload;
      r.compare = held_compare;
      r.joint_speed = 32'(j);
      pending.push_back(r);
    endfunction

    function void check_result(timer_settings_t got);
      timer_settings_t e;
      if (pending.size() == 0) begin
        $error("result item with no request outstanding");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.accepted !== e.accepted) begin
        $error("accepted: expected %0d, got %0d", e.accepted, got.accepted);
        errors++;
      end
      if (got.stopped !== e.stopped) begin
        $error("stopped: expected %0d, got %0d", e.stopped, got.stopped);
        errors++;
      end
      if (got.saturated !== e.saturated) begin
        $error("saturated: expected %0d, got %0d", e.saturated, got.saturated);
        errors++;
      end
      if (got.prescaler !== e.prescaler) begin
        $error("prescaler_setting: expected %0h, got %0h", e.prescaler, got.prescaler);
        errors++;
      end
      if (got.reload !== e.reload) begin
        $error("reload_setting: expected %0h, got %0h", e.reload, got.reload);
        errors++;
      end
      if (got.compare !== e.compare) begin
        $error("compare_setting: expected %0h, got %0h", e.compare, got.compare);
        errors++;
      end
      if (got.joint_speed !== e.joint_speed) begin
        $error("actual_joint_speed: expected %0h, got %0h", e.joint_speed, got.joint_speed);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_joint_speed;
  logic        out_valid;
  logic        out_stall;
  logic        out_accepted;
  logic        out_stopped;
  logic        out_saturated;
  logic [15:0] out_prescaler_setting;
  logic [15:0] out_reload_setting;
  logic [15:0] out_compare_setting;
  logic [31:0] out_actual_joint_speed;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  timer_settings_scoreboard sb;

  // Idling control shared by the sender and the receiver.
  bit quiet;            // When set, neither side idles.
  int hold_cycles;      // Pending long stall of the result channel.
  int unsigned cycle_count;

  stepper_speed_to_timer_settings u_top (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_joint_speed        (in_joint_speed),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_accepted          (out_accepted),
    .out_stopped           (out_stopped),
    .out_saturated         (out_saturated),
    .out_prescaler_setting (out_prescaler_setting),
    .out_reload_setting    (out_reload_setting),
    .out_compare_setting   (out_compare_setting),
    .out_actual_joint_speed(out_actual_joint_speed),
    .psel                  (psel),
    .penable               (penable),
    .pwrite                (pwrite),
    .paddr                 (paddr),
    .pwdata                (pwdata),
    .prdata                (prdata),
    .pready                (pready)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog: the slowest legal run is far below this limit.
  initial begin
    cycle_count = 0;
    forever begin
      @(posedge clk);
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
        $display("stepper_speed_to_timer_settings: mismatch");
        $finish;
      end
    end
  end

  // Writes one register through the APB port: a setup cycle, then an access cycle.
  task automatic write_reg(cfg_reg_t idx, bit [31:0] v);
    @(negedge clk);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= 5'(idx * 4);
    pwdata <= v;
    @(negedge clk);
    penable <= 1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.set_reg(idx, v);
    @(negedge clk);
    psel <= 0;
    penable <= 0;
    pwrite <= 0;
  endtask

  // The block must be idle before registers change: every result returned.
  // Called at a falling edge; it drops the input and returns at a falling edge.
  task automatic wait_idle();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(bit [31:0] clock_hz, bit [31:0] angle, bit [31:0] pulse_ns,
                           bit [31:0] min_speed, bit [31:0] max_speed, bit [31:0] transform);
    wait_idle();
    write_reg(REG_TIMER_CLOCK, clock_hz);
    write_reg(REG_STEP_ANGLE, angle);
    write_reg(REG_PULSE_WIDTH, pulse_ns);
    write_reg(REG_MIN_SPEED, min_speed);
    write_reg(REG_MAX_SPEED, max_speed);
    write_reg(REG_TRANSFORM, transform);
  endtask

  // Offers one item at the current falling edge and holds it until the block
  // takes it. The predictor runs at the edge where the item is taken, and the
  // task returns at a falling edge.
  task automatic send_speed(bit [31:0] js);
    in_valid <= 1;
    in_joint_speed <= js;
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
    sb.note_request(js);
    @(negedge clk);
    if (!quiet && $urandom_range(99) < 38) begin
      in_valid <= 0;
      in_joint_speed <= $urandom;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
  endtask

  // Mostly plausible forward speeds spread over many magnitudes, with some
  // arbitrary bit patterns that are negative and rejected about half the time.
  function automatic bit [31:0] random_speed();
    if ($urandom_range(99) < 20) return $urandom;
    return $urandom_range(32'h7FFFFFFF, 0) >> $urandom_range(31, 0);
  endfunction

  task automatic random_items(int count);
    for (int i = 0; i < count; i++) send_speed(random_speed());
  endtask

  task automatic directed_items();
    send_speed(32'h0000_0000);  // zero speed stops even with no minimum
    send_speed(32'h0000_0001);
    send_speed(32'h7FFF_FFFF);
    send_speed(32'h8000_0000);  // most negative, rejected
    send_speed(32'hFFFF_FFFF);  // minus one LSB, rejected
    send_speed(32'h0001_0000);
    send_speed(32'h0010_0000);
    send_speed(32'h0000_8000);
    send_speed(32'h0200_0000);
    send_speed(32'h0000_0000);
  endtask

  // Result side: random stalls, plus one long hold-off when requested.
  initial begin
    out_stall = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_stall <= 1;
        hold_cycles--;
      end else begin
        out_stall <= !quiet && ($urandom_range(99) < 38);
      end
    end
  end

  initial begin
    timer_settings_t got;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.accepted = out_accepted;
        got.stopped = out_stopped;
        got.saturated = out_saturated;
        got.prescaler = out_prescaler_setting;
        got.reload = out_reload_setting;
        got.compare = out_compare_setting;
        got.joint_speed = out_actual_joint_speed;
        sb.check_result(got);
      end
    end
  end

  initial begin
    sb = new();
    rst_n = 0;
    in_valid = 0;
    in_joint_speed = 0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = 0;
    pwdata = 0;
    quiet = 0;
    hold_cycles = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Reset defaults first.
    directed_items();
    random_items(150);

    // Smallest clock, angle, pulse and factor: prescaler bottoms out, values clip.
    configure(1, 1, 0, 0, 32'hFFFFFFFF, 1);
    directed_items();
    random_items(200);

    // Largest clock, angle and transform factor; this phase runs without any idling.
    quiet = 1;
    configure(32'h0FFFFFFF, 32'hFFFFFFFF, 1000000, 0, 32'hFFFFFFFF, 32'hFFFFFFFF);
    directed_items();
    random_items(200);
    quiet = 0;

    // Minimum and maximum both active. The receiver holds off for a long
    // stretch while the sender keeps offering items.
    configure(84000000, 527061, 10000, 32'h0010_0000, 32'h1000_0000, 65536);
    directed_items();
    hold_cycles = 3000;
    random_items(200);

    // Random settings; halfway through the sender waits for every result.
    configure($urandom_range(32'h0FFFFFFF, 1), $urandom | 1, $urandom_range(1000000, 0),
              $urandom_range(32'h0000FFFF, 0), $urandom_range(32'hFFFFFFFF, 32'h0100_0000),
              $urandom_range(32'h0004_0000, 32'h0000_4000));
    random_items(100);
    wait_idle();
    random_items(100);

    configure(1000000, 200000, 500, 32'h8000, 32'h7FFFFFFF, 32'h20000);
    random_items(250);

    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("stepper_speed_to_timer_settings: match");
    end else begin
      $display("stepper_speed_to_timer_settings: mismatch");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/sstts_pkg.sv
rtl/core/sstts_alu.sv
rtl/core/stepper_speed_to_timer_settings.sv
sim/tb_stepper_speed_to_timer_settings.sv
